@@ hw/rtl/pfd4_pkg.sv @@
// shared types and constants for the polyphase decimating fir
// no dependencies; imported by the input interface and every module of the block
package pfd4_pkg;

	// fixed width of the coefficient slot field
	localparam int COEF_INDEX_W = 7;

	// item modes
	localparam logic MODE_COEF   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_FINISH
	} fsm_state_t;

	// store write strobes from the sequencer
	typedef struct packed {
		logic hist_we;
		logic coef_we;
	} wr_ctl_t;

	// per-tap control traveling down the mac pipeline
	typedef struct packed {
		logic step;
		logic last;
		logic hist_ok;
	} step_ctl_t;

endpackage

@@ hw/rtl/pfd4_in_if.sv @@
// input channel: coefficient writes and audio samples
// depends on pfd4_pkg
interface pfd4_in_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 16
);
	import pfd4_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [COEF_INDEX_W-1:0]        coef_index;
	logic signed [COEF_WIDTH-1:0]   coef_value;
	logic signed [SAMPLE_WIDTH-1:0] in_sample;

	modport source (output valid, mode, coef_index, coef_value, in_sample, input ready);
	modport sink   (input valid, mode, coef_index, coef_value, in_sample, output ready);

endinterface

@@ hw/rtl/pfd4_out_if.sv @@
// output channel: decimated audio samples
// no dependencies
interface pfd4_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_sample;

	modport source (output valid, out_sample, input ready);
	modport sink   (input valid, out_sample, output ready);

endinterface

@@ hw/rtl/pfd4_ctrl.sv @@
// sequencer: ring pointer, phase counter, history fill count and tap walk
// depends on pfd4_pkg
module pfd4_ctrl #(
	parameter int PHASES         = 4,
	parameter int TAPS_PER_PHASE = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	input  logic                                        in_mode,
	input  logic                                        out_free,
	input  logic                                        mac_done,
	output logic                                        ready,
	output logic                                        clear,
	output logic                                        load_out,
	output pfd4_pkg::wr_ctl_t                           wr,
	output pfd4_pkg::step_ctl_t                         step,
	output logic [$clog2(PHASES*TAPS_PER_PHASE)-1:0]    hist_waddr,
	output logic [$clog2(PHASES*TAPS_PER_PHASE)-1:0]    hist_raddr,
	output logic [$clog2(PHASES*TAPS_PER_PHASE)-1:0]    coef_raddr
);
	import pfd4_pkg::*;

	localparam int DEPTH = PHASES * TAPS_PER_PHASE;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(PHASES);
	localparam int TW    = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;

	localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X    = (AW + 1)'(DEPTH);
	localparam logic [AW:0]   PHASES_X   = (AW + 1)'(PHASES);
	localparam logic [PW-1:0] PHASE_LAST = PW'(PHASES - 1);
	localparam logic [TW-1:0] TAP_LAST   = TW'(TAPS_PER_PHASE - 1);

	fsm_state_t    state_q, state_d;
	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;
	logic [PW-1:0] phase_q;
	logic [AW-1:0] k_q;
	logic [TW-1:0] j_q;
	logic [PW-1:0] m_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] off_q;

	logic [AW:0]   rd_x;
	logic [AW:0]   rd_dec_x;
	logic [AW-1:0] base_dec;
	logic [PW-1:0] m_next;

	// next tap of the same phase sits PHASES entries further back in the ring
	assign rd_x     = {1'b0, rd_q};
	assign rd_dec_x = (rd_x >= PHASES_X) ? (rd_x - PHASES_X) : (rd_x + DEPTH_X - PHASES_X);
	assign base_dec = (base_q == '0) ? ADDR_LAST : (base_q - 1'b1);
	assign m_next   = m_q + 1'b1;

	assign hist_waddr = wp_q;
	assign hist_raddr = rd_q;
	assign coef_raddr = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ready    = 1'b0;
		clear    = 1'b0;
		load_out = 1'b0;
		wr       = '0;
		step     = '0;
		case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				if (in_valid) begin
					if (in_mode == MODE_COEF) begin
						wr.coef_we = 1'b1;
					end else begin
						wr.hist_we = 1'b1;
						if (phase_q == '0) begin
							clear   = 1'b1;
							state_d = ST_RUN;
						end
					end
				end
			end
			ST_RUN: begin
				step.step    = 1'b1;
				step.last    = (k_q == ADDR_LAST);
				step.hist_ok = ({1'b0, off_q} < fill_q);
				if (k_q == ADDR_LAST) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (mac_done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			phase_q <= '0;
			k_q     <= '0;
			j_q     <= '0;
			m_q     <= '0;
			base_q  <= '0;
			rd_q    <= '0;
			off_q   <= '0;
		end else begin
			if (wr.hist_we) begin
				wp_q    <= (wp_q == ADDR_LAST) ? '0 : (wp_q + 1'b1);
				phase_q <= (phase_q == PHASE_LAST) ? '0 : (phase_q + 1'b1);
				if (fill_q != DEPTH_X) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (clear) begin
				// walk starts at the newest sample, phase 0 tap 0
				k_q    <= '0;
				j_q    <= '0;
				m_q    <= '0;
				base_q <= wp_q;
				rd_q   <= wp_q;
				off_q  <= '0;
			end else if (step.step) begin
				k_q <= k_q + 1'b1;
				if (j_q == TAP_LAST) begin
					j_q    <= '0;
					m_q    <= m_next;
					base_q <= base_dec;
					rd_q   <= base_dec;
					off_q  <= AW'(m_next);
				end else begin
					j_q   <= j_q + 1'b1;
					rd_q  <= rd_dec_x[AW-1:0];
					off_q <= off_q + AW'(PHASES);
				end
			end
		end
	end

endmodule

@@ hw/rtl/pfd4_store.sv @@
// history ring and coefficient memories with registered reads
// depends on pfd4_pkg
module pfd4_store #(
	parameter int DEPTH        = 128,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pfd4_pkg::wr_ctl_t                     wr,
	input  logic [$clog2(DEPTH)-1:0]              hist_waddr,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
	input  logic [pfd4_pkg::COEF_INDEX_W-1:0]     coef_index,
	input  logic signed [COEF_WIDTH-1:0]          coef_value,
	input  pfd4_pkg::step_ctl_t                   step,
	input  logic [$clog2(DEPTH)-1:0]              hist_raddr,
	input  logic [$clog2(DEPTH)-1:0]              coef_raddr,
	output logic signed [SAMPLE_WIDTH-1:0]        hist_s1,
	output logic signed [COEF_WIDTH-1:0]          coef_s1,
	output logic                                  coef_ok_s1,
	output pfd4_pkg::step_ctl_t                   step_s1
);
	import pfd4_pkg::*;

	localparam int AW = $clog2(DEPTH);
	// one bit above the address so DEPTH itself fits in the compare
	localparam int XW = (AW + 1 > COEF_INDEX_W) ? (AW + 1) : COEF_INDEX_W;

	logic signed [SAMPLE_WIDTH-1:0] hist_mem [DEPTH];
	logic signed [COEF_WIDTH-1:0]   coef_mem [DEPTH];
	logic [DEPTH-1:0]               coef_vld_q;

	logic [XW-1:0] idx_x;
	logic          idx_ok;
	logic [AW-1:0] coef_waddr;

	// slots past the end of the store are dropped
	assign idx_x      = XW'(coef_index);
	assign idx_ok     = (idx_x < XW'(DEPTH));
	assign coef_waddr = idx_x[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.hist_we) begin
			hist_mem[hist_waddr] <= sample_in;
		end
		hist_s1 <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.coef_we && idx_ok) begin
			coef_mem[coef_waddr] <= coef_value;
		end
		coef_s1 <= coef_mem[coef_raddr];
	end

	// a slot never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			coef_ok_s1 <= 1'b0;
			step_s1    <= '0;
		end else begin
			if (wr.coef_we && idx_ok) begin
				coef_vld_q[coef_waddr] <= 1'b1;
			end
			coef_ok_s1 <= coef_vld_q[coef_raddr];
			step_s1    <= step;
		end
	end

endmodule

@@ hw/rtl/pfd4_mac.sv @@
// shared multiply-accumulate unit with round-half-up and saturation
// depends on pfd4_pkg
module pfd4_mac #(
	parameter int DEPTH        = 128,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  pfd4_pkg::step_ctl_t            step_s1,
	input  logic signed [SAMPLE_WIDTH-1:0] hist_s1,
	input  logic signed [COEF_WIDTH-1:0]   coef_s1,
	input  logic                           coef_ok_s1,
	output logic                           done,
	output logic signed [SAMPLE_WIDTH-1:0] result
);
	import pfd4_pkg::*;

	localparam int PRODW = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int SUMW  = PRODW + $clog2(DEPTH);
	// accumulator width capped at 64 bits; a wider sum wraps
	localparam int ACCW  = (SUMW > 64) ? 64 : SUMW;
	localparam int SH    = COEF_WIDTH - 1;

	localparam logic signed [ACCW-1:0] RND    = $signed(ACCW'(1) << (COEF_WIDTH - 2));
	localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACCW-1:0] SAT_LO = ACCW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

	logic signed [SAMPLE_WIDTH-1:0] a_op;
	logic signed [COEF_WIDTH-1:0]   b_op;
	logic signed [PRODW-1:0]        prod_s2;
	step_ctl_t                      step_s2;
	logic signed [ACCW-1:0]         acc_q;
	logic                           done_q;
	logic signed [ACCW-1:0]         rounded;
	logic signed [ACCW-1:0]         shifted;

	// unwritten history and coefficient slots count as zero
	assign a_op = step_s1.hist_ok ? hist_s1 : '0;
	assign b_op = coef_ok_s1 ? coef_s1 : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= a_op * b_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s2 <= '0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			step_s2 <= step_s1;
			done_q  <= step_s2.step && step_s2.last;
			if (clear) begin
				acc_q <= '0;
			end else if (step_s2.step) begin
				acc_q <= acc_q + ACCW'(prod_s2);
			end
		end
	end

	assign rounded = acc_q + RND;
	assign shifted = rounded >>> SH;

	always_comb begin
		if (shifted > SAT_HI) begin
			result = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (shifted < SAT_LO) begin
			result = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			result = shifted[SAMPLE_WIDTH-1:0];
		end
	end

	assign done = done_q;

endmodule

@@ hw/rtl/polyphase_fir_decimate_by4_core.sv @@
// top level of the polyphase decimate-by-PHASES fir
// depends on pfd4_pkg, pfd4_in_if, pfd4_out_if, pfd4_ctrl, pfd4_store, pfd4_mac
//
// usage
//   feed carries two kinds of item: mode 0 writes one coefficient into slot
//   coef_index (phase * TAPS_PER_PHASE + tap), mode 1 pushes one audio sample
//   into the history ring. the first sample of every group of PHASES, the very
//   first one after reset included, starts a filter pass and yields one item on
//   result; the other samples and all coefficient writes yield nothing.
// timing
//   coefficient items and samples that start no pass are taken in idle.
//   a pass walks all PHASES*TAPS_PER_PHASE taps through one shared multiplier,
//   one tap per cycle, then a three-stage read/multiply/accumulate tail:
//   the sum goes to the output register once that is free, and feed is not
//   ready from the start of the pass until the sum is loaded.
// reset
//   arst_n clears the ring pointer, phase counter, history fill count and the
//   coefficient valid bits: history and coefficients read as zero until written.
// stalls
//   the result sits in an output register; while it waits, feed still takes
//   items. a later pass holds its finished sum until that register frees up.
module polyphase_fir_decimate_by4_core #(
	parameter int PHASES         = 4,
	parameter int TAPS_PER_PHASE = 32,
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_WIDTH     = 16
) (
	input logic        clk,
	input logic        arst_n,
	pfd4_in_if.sink    feed,
	pfd4_out_if.source result
);
	import pfd4_pkg::*;

	localparam int DEPTH = PHASES * TAPS_PER_PHASE;
	localparam int AW    = $clog2(DEPTH);

	// sequencer outputs
	logic          ready;
	logic          clear;
	logic          load_out;
	wr_ctl_t       wr;
	step_ctl_t     step;
	logic [AW-1:0] hist_waddr;
	logic [AW-1:0] hist_raddr;
	logic [AW-1:0] coef_raddr;

	// store read side
	logic signed [SAMPLE_WIDTH-1:0] hist_s1;
	logic signed [COEF_WIDTH-1:0]   coef_s1;
	logic                           coef_ok_s1;
	step_ctl_t                      step_s1;

	// mac side
	logic                           mac_done;
	logic signed [SAMPLE_WIDTH-1:0] mac_result;

	// output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic                           out_free;

	// register can take a new result if empty or being drained this cycle
	assign out_free = !out_valid_q || result.ready;

	pfd4_ctrl #(
		.PHASES         (PHASES),
		.TAPS_PER_PHASE (TAPS_PER_PHASE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (feed.valid),
		.in_mode    (feed.mode),
		.out_free   (out_free),
		.mac_done   (mac_done),
		.ready      (ready),
		.clear      (clear),
		.load_out   (load_out),
		.wr         (wr),
		.step       (step),
		.hist_waddr (hist_waddr),
		.hist_raddr (hist_raddr),
		.coef_raddr (coef_raddr)
	);

	pfd4_store #(
		.DEPTH        (DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.hist_waddr (hist_waddr),
		.sample_in  (feed.in_sample),
		.coef_index (feed.coef_index),
		.coef_value (feed.coef_value),
		.step       (step),
		.hist_raddr (hist_raddr),
		.coef_raddr (coef_raddr),
		.hist_s1    (hist_s1),
		.coef_s1    (coef_s1),
		.coef_ok_s1 (coef_ok_s1),
		.step_s1    (step_s1)
	);

	pfd4_mac #(
		.DEPTH        (DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (clear),
		.step_s1    (step_s1),
		.hist_s1    (hist_s1),
		.coef_s1    (coef_s1),
		.coef_ok_s1 (coef_ok_s1),
		.done       (mac_done),
		.result     (mac_result)
	);

	// result register, valid held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= mac_result;
		end
	end

	assign feed.ready        = ready;
	assign result.valid      = out_valid_q;
	assign result.out_sample = out_q;

endmodule
